// ----- rtl/core/window_zscore_normalizer_assert.svh -----
// ----------------------------------------------------------------------------
// window_zscore_normalizer_assert.svh
// assertion macros for the port checker
// ----------------------------------------------------------------------------
`ifndef WINDOW_ZSCORE_NORMALIZER_ASSERT_SVH
`define WINDOW_ZSCORE_NORMALIZER_ASSERT_SVH

// expression must never hold outside reset
`define WZN_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("wzn: forbidden condition seen");

// antecedent in one cycle implies consequent in the next
`define WZN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wzn: expected follow-up missing");

`endif

// ----- rtl/core/wzn_pkg.sv -----
// ----------------------------------------------------------------------------
// wzn_pkg
// constants and types for the window z-score normaliser
// ----------------------------------------------------------------------------
package wzn_pkg;

    localparam int NUM_CH               = 6;
    localparam int DATA_W               = 16;
    localparam int FRAC_BITS            = 11;
    localparam int DEFAULT_WINDOW_DEPTH = 64;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // accumulator and divider widths, sized for the largest window
    localparam int SUM_W      = 22;
    localparam int SQ_W       = 38;
    localparam int DVD_W      = 38;
    localparam int DVS_W      = 18;
    localparam int NORM_STEPS = 29;

    // configuration port
    localparam int              PADDR_W      = 3;
    localparam logic [2:0]      REG_EPSILON  = 3'd0;
    localparam logic [15:0]     EPSILON_RST  = 16'd1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SUM  = 9'b000000010,
        S_MDIV = 9'b000000100,
        S_VAR  = 9'b000001000,
        S_VDIV = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_NORM = 9'b001000000,
        S_NDIV = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

endpackage

// ----- rtl/core/window_zscore_normalizer.sv -----
// ----------------------------------------------------------------------------
// window_zscore_normalizer
// per-channel z-score of a window of six-axis samples, iterative datapath
// ----------------------------------------------------------------------------
// channel   dir  word
// s_*       in   six raw channels + tlast (window end)
// m_*       out  six Q4.11 channels + tlast (last result) + tuser (overflow)
// apb       in   epsilon register at address 0
//
// non-last samples are stored while idle. closing a window runs the per-channel
// sum, mean, variance and square root, then one normalising divide per channel
// per result, on the single shared restoring divider (one quotient bit per
// cycle) and the bit-serial square root. s_tready is low from window close
// until the last result is taken; a stalled m_tready holds the result word in place.
// reset is asynchronous, active low; the sample store is not cleared.
// ----------------------------------------------------------------------------
module window_zscore_normalizer
    import wzn_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [NUM_CH*DATA_W-1:0]   s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic                       s_tlast,   // sample_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [NUM_CH*DATA_W-1:0]   m_tdata,   // norm_accel_x .. norm_gyro_z
    output logic                       m_tlast,   // result_last
    output logic                       m_tuser,   // overflow
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
    localparam logic [2:0] LAST_CH = 3'(NUM_CH - 1);

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       drop_reg, drop_next;
    logic [15:0]                eps_reg;
    logic [2:0]                 ch_reg, ch_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next;
    logic [1:0]                 ph_reg, ph_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [31:0]                prod_reg, prod_next;
    logic [DVD_W-1:0]           dv_q_reg, dv_q_next;
    logic [DVS_W-1:0]           dv_rem_reg, dv_rem_next;
    logic [DVS_W-1:0]           dv_d_reg, dv_d_next;
    logic [5:0]                 dv_cnt_reg, dv_cnt_next;
    logic                       neg_reg, neg_next;
    logic [31:0]                rt_v_reg, rt_v_next;
    logic [31:0]                rt_res_reg, rt_res_next;
    logic [31:0]                rt_bit_reg, rt_bit_next;

    logic signed [15:0]         mean_reg [NUM_CH];
    logic [16:0]                scale_reg [NUM_CH];
    logic [15:0]                out_reg [NUM_CH];
    logic [NUM_CH*DATA_W-1:0]   mem [WINDOW_DEPTH];
    logic [NUM_CH*DATA_W-1:0]   rd_data_reg;

    logic                       wr_en;
    logic [NUM_CH*DATA_W-1:0]   wr_word;
    logic                       mean_we, scale_we, out_we;
    logic signed [15:0]         mean_val;
    logic [16:0]                scale_val;
    logic [15:0]                out_val;

    logic signed [15:0]         cur_x;
    logic signed [15:0]         mean_cur;
    logic [16:0]                scale_cur;
    logic signed [16:0]         diff;
    logic [16:0]                diff_abs;
    logic                       last_idx;
    logic [DVS_W:0]             rem_sh, rem_sub;
    logic                       dv_ge;
    logic [31:0]                rt_sum;
    logic                       rt_ge;
    logic [SUM_W-1:0]           sum_abs;
    logic [16:0]                mq, mval;
    logic [28:0]                qm;
    logic [16:0]                std_eps;
    logic                       cfg_wr;

    // sign extension of the low sample bits on entry
    always_comb
    begin
        logic [15:0] t;
        for (int c = 0; c < NUM_CH; c++)
        begin
            t = s_tdata[c*DATA_W +: DATA_W] << (DATA_W - SAMPLE_WIDTH);
            wr_word[c*DATA_W +: DATA_W] = 16'($signed(t) >>> (DATA_W - SAMPLE_WIDTH));
        end
    end

    // shared operand selection
    assign cur_x     = $signed(rd_data_reg[DATA_W*ch_reg +: DATA_W]);
    assign mean_cur  = mean_reg[ch_reg];
    assign scale_cur = scale_reg[ch_reg];
    assign diff      = {cur_x[15], cur_x} - {mean_cur[15], mean_cur};
    assign diff_abs  = diff[16] ? 17'(-diff) : 17'(diff);
    assign last_idx  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    // restoring divider step
    assign rem_sh  = {dv_rem_reg, dv_q_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dv_d_reg};
    assign dv_ge   = rem_sh >= {1'b0, dv_d_reg};

    // square root step
    assign rt_sum = rt_res_reg + rt_bit_reg;
    assign rt_ge  = rt_v_reg >= rt_sum;

    assign sum_abs = acc_next[SUM_W-1] ? SUM_W'(-acc_next) : SUM_W'(acc_next);
    assign mq      = dv_q_reg[16:0];
    assign mval    = neg_reg ? 17'(-(mq + 17'(dv_rem_reg != '0))) : mq;
    assign qm      = dv_q_reg[28:0];
    assign std_eps = 17'(rt_res_reg[15:0]) + 17'(eps_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        ch_next     = ch_reg;
        idx_next    = idx_reg;
        ph_next     = ph_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        prod_next   = prod_reg;
        dv_q_next   = dv_q_reg;
        dv_rem_next = dv_rem_reg;
        dv_d_next   = dv_d_reg;
        dv_cnt_next = dv_cnt_reg;
        neg_next    = neg_reg;
        rt_v_next   = rt_v_reg;
        rt_res_next = rt_res_reg;
        rt_bit_next = rt_bit_reg;
        wr_en       = 1'b0;
        mean_we     = 1'b0;
        scale_we    = 1'b0;
        out_we      = 1'b0;
        mean_val    = mval[15:0];
        scale_val   = (std_eps == '0) ? 17'd1 : std_eps;
        out_val     = '0;

        // divider runs whenever it has bits left
        if (dv_cnt_reg != '0)
        begin
            dv_rem_next = dv_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dv_q_next   = {dv_q_reg[DVD_W-2:0], dv_ge};
            dv_cnt_next = dv_cnt_reg - 6'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = S_SUM;
                        ch_next    = '0;
                        idx_next   = '0;
                        ph_next    = '0;
                        acc_next   = '0;
                    end
                end
            end
            S_SUM:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    acc_next = acc_reg + SUM_W'(cur_x);
                    if (last_idx)
                    begin
                        state_next  = S_MDIV;
                        neg_next    = acc_next[SUM_W-1];
                        dv_q_next   = DVD_W'(sum_abs) << (DVD_W - SUM_W);
                        dv_rem_next = '0;
                        dv_d_next   = DVS_W'(count_reg);
                        dv_cnt_next = 6'(SUM_W);
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                        ph_next  = 2'd0;
                    end
                end
            end
            S_MDIV:
            begin
                if (dv_cnt_reg == '0)
                begin
                    mean_we    = 1'b1;
                    state_next = S_VAR;
                    idx_next   = '0;
                    ph_next    = '0;
                    sq_next    = '0;
                end
            end
            S_VAR:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    prod_next = diff_abs[15:0] * diff_abs[15:0];
                    ph_next   = 2'd2;
                end
                else
                begin
                    sq_next = sq_reg + SQ_W'(prod_reg);
                    if (last_idx)
                    begin
                        state_next  = S_VDIV;
                        dv_q_next   = DVD_W'(sq_next) << (DVD_W - SQ_W);
                        dv_rem_next = '0;
                        dv_d_next   = DVS_W'(count_reg);
                        dv_cnt_next = 6'(SQ_W);
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                        ph_next  = 2'd0;
                    end
                end
            end
            S_VDIV:
            begin
                if (dv_cnt_reg == '0)
                begin
                    state_next  = S_SQRT;
                    rt_v_next   = dv_q_reg[31:0];
                    rt_res_next = '0;
                    rt_bit_next = 32'h4000_0000;
                end
            end
            S_SQRT:
            begin
                if (rt_bit_reg != '0)
                begin
                    if (rt_ge)
                    begin
                        rt_v_next   = rt_v_reg - rt_sum;
                        rt_res_next = (rt_res_reg >> 1) + rt_bit_reg;
                    end
                    else
                    begin
                        rt_res_next = rt_res_reg >> 1;
                    end
                    rt_bit_next = rt_bit_reg >> 2;
                end
                else
                begin
                    scale_we = 1'b1;
                    idx_next = '0;
                    ph_next  = '0;
                    if (ch_reg == LAST_CH)
                    begin
                        state_next = S_NORM;
                        ch_next    = '0;
                    end
                    else
                    begin
                        state_next = S_SUM;
                        ch_next    = ch_reg + 3'd1;
                        acc_next   = '0;
                    end
                end
            end
            S_NORM:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    state_next  = S_NDIV;
                    neg_next    = diff[16];
                    dv_q_next   = ((DVD_W'(diff_abs[15:0]) << (FRAC_BITS + 1))
                                   + DVD_W'(scale_cur)) << (DVD_W - NORM_STEPS);
                    dv_rem_next = '0;
                    dv_d_next   = {scale_cur, 1'b0};
                    dv_cnt_next = 6'(NORM_STEPS);
                end
            end
            S_NDIV:
            begin
                if (dv_cnt_reg == '0)
                begin
                    out_we = 1'b1;
                    if (neg_reg)
                        out_val = (qm > 29'd32768) ? 16'h8000 : 16'(-qm);
                    else
                        out_val = (qm > 29'd32767) ? 16'h7fff : qm[15:0];
                    if (ch_reg == LAST_CH)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_NORM;
                        ch_next    = ch_reg + 3'd1;
                        ph_next    = 2'd1;
                    end
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    if (last_idx)
                    begin
                        state_next = S_IDLE;
                        count_next = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_NORM;
                        idx_next   = idx_reg + ADDR_W'(1);
                        ch_next    = '0;
                        ph_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            ch_reg    <= '0;
            idx_reg   <= '0;
            ph_reg    <= '0;
            dv_cnt_reg <= '0;
            rt_bit_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            ch_reg     <= ch_next;
            idx_reg    <= idx_next;
            ph_reg     <= ph_next;
            dv_cnt_reg <= dv_cnt_next;
            rt_bit_reg <= rt_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        prod_reg   <= prod_next;
        dv_q_reg   <= dv_q_next;
        dv_rem_reg <= dv_rem_next;
        dv_d_reg   <= dv_d_next;
        neg_reg    <= neg_next;
        rt_v_reg   <= rt_v_next;
        rt_res_reg <= rt_res_next;
    end

    // per-channel statistics, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                mean_reg[c]  <= '0;
                scale_reg[c] <= '0;
            end
        end
        else
        begin
            if (mean_we)
                mean_reg[ch_reg] <= mean_val;
            if (scale_we)
                scale_reg[ch_reg] <= scale_val;
        end
    end

    // result word being built
    always_ff @(posedge clk)
    begin
        if (out_we)
            out_reg[ch_reg] <= out_val;
    end

    // sample store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[ADDR_W-1:0]] <= wr_word;
        rd_data_reg <= mem[idx_reg];
    end

    // configuration register
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_EPSILON);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPSILON_RST;
        else if (cfg_wr)
            eps_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_EPSILON) ? {16'd0, eps_reg} : 32'd0;

    // stream ports
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
            m_tdata[c*DATA_W +: DATA_W] = out_reg[c];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast  = last_idx;
    assign m_tuser  = drop_reg;

endmodule

// ----- rtl/core/wzn_port_checker.sv -----
// ----------------------------------------------------------------------------
// wzn_port_checker
// port-level checks on the window z-score normaliser
// ----------------------------------------------------------------------------
`include "window_zscore_normalizer_assert.svh"

module wzn_port_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic s_tlast,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    // input side closed while results are offered
    `WZN_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid)

    // a stalled result word stays offered
    `WZN_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // a mid-window sample leaves the input open
    `WZN_ASSERT_NEXT(a_mid_open, s_tvalid && s_tready && !s_tlast, s_tready)

    // taking the last result reopens the input
    `WZN_ASSERT_NEXT(a_reopen, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

bind window_zscore_normalizer wzn_port_checker u_wzn_port_checker (.*);

// ----- verif/window_zscore_checker.sv -----
// ----------------------------------------------------------------------------
// window_zscore_checker
// watches the sample and result streams, predicts each normalised word and
// compares it field by field with what the block emits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_zscore_checker
    import wzn_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [NUM_CH*DATA_W-1:0] s_tdata,
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [NUM_CH*DATA_W-1:0] m_tdata,
    input  logic                     m_tlast,
    input  logic                     m_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output int                       fail_count,
    output int                       pending_words
);

    typedef struct packed {
        logic [NUM_CH*DATA_W-1:0] chans;
        logic                     last;
        logic                     ovf;
    } norm_word_t;

    norm_word_t           norm_queue[$];
    longint               window_buf[WINDOW_DEPTH][NUM_CH];
    int                   fill;
    bit                   dropped;
    longint               mean_c[NUM_CH];
    longint               scale_c[NUM_CH];
    logic [15:0]          eps;

    assign pending_words = norm_queue.size();

    // mismatch report
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // floor division for signed dividend, positive divisor
    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    // round half away from zero, saturate to q4.11
    function automatic logic [15:0] scaled_ch(input longint x, input int c);
        longint d, s, mag, qm;
        d   = x - mean_c[c];
        s   = (scale_c[c] != 0) ? scale_c[c] : 1;
        mag = ((d < 0) ? -d : d) << FRAC_BITS;
        qm  = (2 * mag + s) / (2 * s);
        if (d < 0)
        begin
            if (qm > 32768)
                qm = 32768;
            return 16'(-qm);
        end
        if (qm > 32767)
            qm = 32767;
        return 16'(qm);
    endfunction

    // window close: statistics then one expected word per stored sample
    task automatic close_window();
        longint sum, sq, d;
        norm_word_t w;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum = 0;
            for (int i = 0; i < fill; i++)
                sum += window_buf[i][c];
            mean_c[c] = floor_div(sum, fill);
            sq = 0;
            for (int i = 0; i < fill; i++)
            begin
                d = window_buf[i][c] - mean_c[c];
                sq += d * d;
            end
            scale_c[c] = int_sqrt(sq / fill) + eps;
        end
        for (int i = 0; i < fill; i++)
        begin
            for (int c = 0; c < NUM_CH; c++)
                w.chans[c*DATA_W +: DATA_W] = scaled_ch(window_buf[i][c], c);
            w.last = (i == fill - 1);
            w.ovf  = dropped;
            norm_queue.push_back(w);
        end
        fill    = 0;
        dropped = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        norm_word_t exp_w;
        logic [SAMPLE_WIDTH-1:0] raw;
        if (!rst_n)
        begin
            fill       = 0;
            dropped    = 0;
            eps        = EPSILON_RST;
            fail_count = 0;
            norm_queue.delete();
            for (int c = 0; c < NUM_CH; c++)
            begin
                mean_c[c]  = 0;
                scale_c[c] = 0;
            end
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && paddr == REG_EPSILON)
                eps = pwdata[15:0];
            // result word
            if (m_tvalid && m_tready)
            begin
                if (norm_queue.size() == 0)
                    report_mismatch("unexpected word", m_tdata[31:0], 0);
                else
                begin
                    exp_w = norm_queue.pop_front();
                    for (int c = 0; c < NUM_CH; c++)
                        if (m_tdata[c*DATA_W +: DATA_W] !== exp_w.chans[c*DATA_W +: DATA_W])
                            report_mismatch($sformatf("channel %0d", c),
                                            m_tdata[c*DATA_W +: DATA_W],
                                            exp_w.chans[c*DATA_W +: DATA_W]);
                    if (m_tlast !== exp_w.last)
                        report_mismatch("last", m_tlast, exp_w.last);
                    if (m_tuser !== exp_w.ovf)
                        report_mismatch("overflow", m_tuser, exp_w.ovf);
                end
            end
            // sample word
            if (s_tvalid && s_tready)
            begin
                if (fill < WINDOW_DEPTH)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        raw = s_tdata[c*DATA_W +: SAMPLE_WIDTH];
                        window_buf[fill][c] = longint'($signed(raw));
                    end
                    fill++;
                end
                else
                    dropped = 1;
                if (s_tlast)
                    close_window();
            end
        end
    end

endmodule

// ----- verif/tb_window_zscore_normalizer.sv -----
// ----------------------------------------------------------------------------
// tb_window_zscore_normalizer
// drives sample windows and epsilon settings with random idling on both
// streams; the checker predicts and compares every normalised word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_zscore_normalizer;
    import wzn_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [NUM_CH*DATA_W-1:0] s_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    logic                     s_tlast;   // sample_last
    logic                     m_tvalid;
    logic                     m_tready;
    logic [NUM_CH*DATA_W-1:0] m_tdata;   // norm_accel_x .. norm_gyro_z
    logic                     m_tlast;   // result_last
    logic                     m_tuser;   // overflow
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending_words;
    int                       send_idle;
    int                       recv_stall;

    window_zscore_normalizer DUT (.*);
    window_zscore_checker    u_checker (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #400ms;
        $display("FAILURE");
        $finish;
    end

    // receiver with random stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    task automatic write_epsilon(input logic [15:0] val);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= REG_EPSILON;
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // wait until every word is taken and the block is idle again
    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_words != 0 || !s_tready)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic send_sample(input logic [NUM_CH*DATA_W-1:0] d, input logic l);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [NUM_CH*DATA_W-1:0] rand_sample(input int kind);
        logic [NUM_CH*DATA_W-1:0] d;
        for (int c = 0; c < NUM_CH; c++)
            case (kind)
                0: d[c*DATA_W +: DATA_W] = 16'($urandom);
                1: d[c*DATA_W +: DATA_W] = 16'($urandom_range(40) - 20);
                default: d[c*DATA_W +: DATA_W] = $urandom_range(1) ? 16'h7fff : 16'h8000;
            endcase
        return d;
    endfunction

    // one window of n samples, then release the input
    task automatic send_window(input int n, input int kind);
        for (int i = 0; i < n; i++)
            send_sample(rand_sample(kind), i == n - 1);
        s_tvalid <= 0;
        @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tlast  = 0;
        m_tready = 0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        send_idle  = 0;
        recv_stall = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single sample, extremes, zero epsilon, maximum epsilon
        send_window(1, 0);
        send_sample({6{16'h7fff}}, 0);
        send_sample({6{16'h8000}}, 0);
        send_sample({6{16'hffff}}, 0);
        send_sample({6{16'h0000}}, 1);
        send_window(4, 2);
        drain();
        write_epsilon(16'd0);
        send_window(3, 2);
        send_sample({6{16'h1234}}, 0);
        send_sample({6{16'h1234}}, 1);
        drain();
        write_epsilon(16'hffff);
        send_window(5, 0);
        drain();
        write_epsilon(16'd1);

        // random windows over the idling phases, one overflowing window
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle  = (phase == 1 || phase == 3) ? ((phase == 1) ? 47 : 26) : 0;
            recv_stall = (phase == 2) ? 47 : ((phase == 3) ? 26 : 0);
            if (phase == 1)
            begin
                send_window(66, 1);
                drain();
                write_epsilon(16'($urandom_range(1, 300)));
            end
            for (int w = 0; w < 4; w++)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
                send_window(n, $urandom_range(2));
            end
            drain();
            write_epsilon(16'($urandom));
        end

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
